// ===== rtl/core/fmsm_pkg.sv =====
`default_nettype none
package fmsm_pkg;
	localparam int FramePixels = 65536;
	localparam int AddrW = $clog2(FramePixels);
	localparam int CountW = AddrW + 1;
	localparam int ValW = 24;
	localparam int SumW = ValW + CountW;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_WEIGHT_NEAR = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_WEIGHT_SECOND = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_WEIGHT_THIRD = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WEIGHT_FAR = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MAG_GAIN = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic KIND_STATS = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [15:0] flow0_x;
		logic signed [15:0] flow0_y;
		logic signed [15:0] flow1_x;
		logic signed [15:0] flow1_y;
		logic signed [15:0] flow2_x;
		logic signed [15:0] flow2_y;
		logic signed [15:0] flow3_x;
		logic signed [15:0] flow3_y;
		logic frame_end;
	} cmd_t;

	typedef struct packed {
		logic result_kind;
		logic [15:0] saliency;
		logic [23:0] max_value;
		logic [23:0] mean_value;
		logic last_pixel;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/core/flow_motion_saliency_map_top.sv =====
`default_nettype none
// Load: per flow vector a radicand, 16-step square root, gain, weight and accumulate,
// then one store; no result unless frame_end. frame_end load: a mean divide follows,
// then the statistics result. Read: memory read, then a restoring divide, then the pixel
// result; a read while no frame is closed or past the last stored pixel gives no result.
// One item at a time; busy is high while an item is in work. Results cannot be stalled.
// After reset the value store is cleared one entry a cycle, every entry in turn, busy high.
module flow_motion_saliency_map_top import fmsm_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire cmd_t cmd,
	output logic busy,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [CfgIdxW-1:0] cfg_index,
	input wire [15:0] cfg_data,
	output logic result_valid,
	output result_t result
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SQRT, ST_GAIN, ST_WEIGHT, ST_ACC, ST_STORE,
		ST_DIV, ST_RD, ST_RDW, ST_DONE
	} state_t;

	state_t state_q;
	logic [15:0] w_q [4];
	logic [15:0] gain_q;
	logic [ValW-1:0] mem [FramePixels];
	logic [ValW-1:0] rd_data_q;
	logic [CountW-1:0] count_q;
	logic [ValW-1:0] max_q;
	logic [SumW-1:0] sum_q;
	logic [CountW-1:0] rptr_q;
	logic done_q;
	logic [AddrW-1:0] clr_q;
	cmd_t cmd_q;
	logic [1:0] vec_q;
	logic [4:0] step_q;
	logic [32:0] rad_q;
	logic [16:0] root_q;
	logic [33:0] rem_q;
	logic [ValW-1:0] scaled_q;
	logic [39:0] prod_q;
	logic [41:0] acc_q;
	logic div_mean_q;
	logic [5:0] dstep_q;
	logic [SumW-1:0] dnum_q;
	logic [SumW-1:0] dquo_q;
	logic [SumW:0] drem_q;
	logic [SumW-1:0] dden_q;
	logic last_q;

	logic [15:0] ax, ay;
	logic [33:0] trial;
	logic [SumW:0] dshift;
	logic [ValW-1:0] sat_val;

	always_comb begin
		unique case (vec_q)
			2'd0: begin ax = cmd_q.flow0_x[15] ? 16'(-cmd_q.flow0_x) : cmd_q.flow0_x;
				ay = cmd_q.flow0_y[15] ? 16'(-cmd_q.flow0_y) : cmd_q.flow0_y; end
			2'd1: begin ax = cmd_q.flow1_x[15] ? 16'(-cmd_q.flow1_x) : cmd_q.flow1_x;
				ay = cmd_q.flow1_y[15] ? 16'(-cmd_q.flow1_y) : cmd_q.flow1_y; end
			2'd2: begin ax = cmd_q.flow2_x[15] ? 16'(-cmd_q.flow2_x) : cmd_q.flow2_x;
				ay = cmd_q.flow2_y[15] ? 16'(-cmd_q.flow2_y) : cmd_q.flow2_y; end
			default: begin ax = cmd_q.flow3_x[15] ? 16'(-cmd_q.flow3_x) : cmd_q.flow3_x;
				ay = cmd_q.flow3_y[15] ? 16'(-cmd_q.flow3_y) : cmd_q.flow3_y; end
		endcase
		// one radicand bit pair per step, 32-bit radicand
		trial = {rem_q[31:0], rad_q[31:30]} - {root_q[15:0], 2'b01};
		dshift = {drem_q[SumW-1:0], dnum_q[SumW-1]};
		sat_val = (acc_q[41:16] > 26'(24'hFFFFFF)) ? 24'hFFFFFF : acc_q[39:16];
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q] <= '0;
		else if (state_q == ST_STORE && count_q < CountW'(FramePixels))
			mem[count_q[AddrW-1:0]] <= sat_val;
		rd_data_q <= mem[rptr_q[AddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			w_q[0] <= 16'd52429; w_q[1] <= 16'd39322;
			w_q[2] <= 16'd26214; w_q[3] <= 16'd13107;
			gain_q <= 16'd2570;
			count_q <= '0; max_q <= '0; sum_q <= '0; rptr_q <= '0; done_q <= 1'b0;
			clr_q <= '0; result_valid <= 1'b0; result <= '0;
			vec_q <= '0; step_q <= '0; dstep_q <= '0; div_mean_q <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_DONE);
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WEIGHT_NEAR: w_q[0] <= cfg_data;
					REG_WEIGHT_SECOND: w_q[1] <= cfg_data;
					REG_WEIGHT_THIRD: w_q[2] <= cfg_data;
					REG_WEIGHT_FAR: w_q[3] <= cfg_data;
					REG_MAG_GAIN: gain_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AddrW'(FramePixels - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (start) begin
					cmd_q <= cmd;
					if (cmd.operation == OP_LOAD) begin
						if (done_q) begin
							count_q <= '0; max_q <= '0; sum_q <= '0;
							rptr_q <= '0; done_q <= 1'b0;
						end
						vec_q <= '0; acc_q <= '0; step_q <= '0;
						state_q <= ST_SQRT;
					end else if (done_q && rptr_q < count_q) begin
						state_q <= ST_RD;
					end
				end
				ST_SQRT: begin
					if (step_q == 5'd0) begin
						rad_q <= 33'(ax) * 33'(ax) + 33'(ay) * 33'(ay);
						rem_q <= '0; root_q <= '0; step_q <= 5'd1;
					end else begin
						rad_q <= {rad_q[30:0], 2'b00};
						if (!trial[33]) begin
							rem_q <= trial; root_q <= {root_q[15:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], rad_q[31:30]};
							root_q <= {root_q[15:0], 1'b0};
						end
						if (step_q == 5'd16) state_q <= ST_GAIN;
						step_q <= step_q + 1'b1;
					end
				end
				ST_GAIN: begin
					scaled_q <= ValW'((root_q * 33'(gain_q)) >> 8);
					state_q <= ST_WEIGHT;
				end
				ST_WEIGHT: begin
					prod_q <= scaled_q * w_q[vec_q];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + 42'(prod_q);
					step_q <= '0;
					vec_q <= vec_q + 1'b1;
					state_q <= (vec_q == 2'd3) ? ST_STORE : ST_SQRT;
				end
				ST_STORE: begin
					if (count_q < CountW'(FramePixels)) begin
						count_q <= count_q + 1'b1;
						if (sat_val > max_q) max_q <= sat_val;
						sum_q <= sum_q + SumW'(sat_val);
					end
					if (cmd_q.frame_end) begin
						done_q <= 1'b1; rptr_q <= '0;
						state_q <= ST_DIV; div_mean_q <= 1'b1; dstep_q <= '0;
					end else state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: begin
					div_mean_q <= 1'b0; dstep_q <= '0;
					last_q <= (rptr_q + 1'b1 == count_q);
					rptr_q <= rptr_q + 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dstep_q == 6'd0) begin
						dnum_q <= div_mean_q ? sum_q : SumW'({rd_data_q, 16'h0000});
						dden_q <= div_mean_q ? SumW'(count_q) : SumW'(max_q);
						drem_q <= '0; dquo_q <= '0;
						dstep_q <= 6'd1;
					end else if (dstep_q <= 6'(SumW)) begin
						dnum_q <= dnum_q << 1;
						if (dshift >= {1'b0, dden_q}) begin
							drem_q <= dshift - {1'b0, dden_q};
							dquo_q <= {dquo_q[SumW-2:0], 1'b1};
						end else begin
							drem_q <= dshift;
							dquo_q <= {dquo_q[SumW-2:0], 1'b0};
						end
						dstep_q <= dstep_q + 1'b1;
					end else state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (div_mean_q) begin
						result <= '{result_kind: KIND_STATS, saliency: 16'd0,
							max_value: max_q,
							mean_value: (count_q == '0) ? 24'd0 : dquo_q[ValW-1:0],
							last_pixel: 1'b0};
					end else begin
						result <= '{result_kind: KIND_PIXEL,
							saliency: (max_q == '0) ? 16'd0 :
								(dquo_q > SumW'(16'hFFFF)) ? 16'hFFFF : dquo_q[15:0],
							max_value: 24'd0, mean_value: 24'd0,
							last_pixel: last_q};
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(FramePixels)) else $error("pixel count overflow");
	a_rptr: assert property (@(posedge clk) disable iff (!arst_n)
		rptr_q <= count_q) else $error("read pointer past count");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == ST_DONE) else $error("stray result");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
	import fmsm_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam int SettleCycles = 100;
	localparam logic [CfgIdxW-1:0] RegCount = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic result_valid;
	result_t result;

	flow_motion_saliency_map_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always #10 clk = ~clk;

	// shadow copy of the block state
	logic [15:0] weights [5];
	logic [23:0] sal_store [FramePixels];
	int unsigned pix_count;
	logic [23:0] frame_max;
	logic [40:0] frame_sum;
	int unsigned read_ptr;
	bit frame_closed;

	result_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	int sender_idle_pct = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] gained_magnitude(logic signed [15:0] x,
		logic signed [15:0] y);
		logic [63:0] sq;
		longint sx;
		longint sy;
		sx = x;
		sy = y;
		sq = sx * sx + sy * sy;
		return (int_sqrt(sq) * weights[REG_MAG_GAIN]) >> 8;
	endfunction

	function automatic logic [23:0] weighted_saliency(cmd_t c);
		logic [63:0] acc;
		acc = gained_magnitude(c.flow0_x, c.flow0_y) * weights[REG_WEIGHT_NEAR]
			+ gained_magnitude(c.flow1_x, c.flow1_y) * weights[REG_WEIGHT_SECOND]
			+ gained_magnitude(c.flow2_x, c.flow2_y) * weights[REG_WEIGHT_THIRD]
			+ gained_magnitude(c.flow3_x, c.flow3_y) * weights[REG_WEIGHT_FAR];
		acc = acc >> 16;
		return (acc > 64'hFF_FFFF) ? 24'hFF_FFFF : acc[23:0];
	endfunction

	// updates the shadow state for one accepted transaction
	task automatic predict_saliency(cmd_t c);
		result_t r;
		logic [23:0] val;
		logic [39:0] q;
		r = '0;
		if (c.operation == OP_LOAD) begin
			if (frame_closed) begin
				pix_count = 0;
				frame_max = 0;
				frame_sum = 0;
				read_ptr = 0;
				frame_closed = 0;
			end
			val = weighted_saliency(c);
			if (pix_count < FramePixels) begin
				sal_store[pix_count] = val;
				pix_count++;
				if (val > frame_max) frame_max = val;
				frame_sum = frame_sum + val;
			end
			if (c.frame_end) begin
				frame_closed = 1;
				read_ptr = 0;
				r.result_kind = KIND_STATS;
				r.max_value = frame_max;
				r.mean_value = (pix_count != 0) ? 24'(frame_sum / pix_count) : 24'd0;
				expected_results.push_back(r);
			end
		end else begin
			if (!frame_closed || read_ptr >= pix_count) return;
			val = sal_store[read_ptr];
			r.result_kind = KIND_PIXEL;
			if (frame_max != 0) begin
				q = {val, 16'd0} / frame_max;
				r.saliency = (q > 40'd65535) ? 16'hFFFF : q[15:0];
			end
			r.last_pixel = (read_ptr + 1 == pix_count);
			read_ptr++;
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.result_kind !== exp_r.result_kind
						|| result.saliency !== exp_r.saliency
						|| result.max_value !== exp_r.max_value
						|| result.mean_value !== exp_r.mean_value
						|| result.last_pixel !== exp_r.last_pixel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: kind %0d/%0d sal %0d/%0d max %0d/%0d mean %0d/%0d last %0d/%0d (exp/act)",
							exp_r.result_kind, result.result_kind, exp_r.saliency,
							result.saliency, exp_r.max_value, result.max_value,
							exp_r.mean_value, result.mean_value, exp_r.last_pixel,
							result.last_pixel);
				end
			end
		end
	end

	// start stays high across back-to-back transactions
	task automatic send_cmd(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_saliency(c);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx < RegCount) weights[idx] = data;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_flow();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t load_cmd(bit last_one);
		cmd_t c;
		c.operation = OP_LOAD;
		c.flow0_x = rand_flow();
		c.flow0_y = rand_flow();
		c.flow1_x = rand_flow();
		c.flow1_y = rand_flow();
		c.flow2_x = rand_flow();
		c.flow2_y = rand_flow();
		c.flow3_x = rand_flow();
		c.flow3_y = rand_flow();
		c.frame_end = last_one;
		return c;
	endfunction

	function automatic cmd_t read_cmd();
		cmd_t c;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		c.operation = OP_READ;
		return c;
	endfunction

	function automatic cmd_t fill_cmd(logic [15:0] v, bit last_one);
		cmd_t c;
		c = '0;
		c.operation = OP_LOAD;
		{c.flow0_x, c.flow0_y, c.flow1_x, c.flow1_y} = {4{v}};
		{c.flow2_x, c.flow2_y, c.flow3_x, c.flow3_y} = {4{v}};
		c.frame_end = last_one;
		return c;
	endfunction

	task automatic test_read_before_frame();
		send_cmd(read_cmd());
		send_cmd(read_cmd());
		wait_idle();
	endtask

	task automatic test_field_extremes();
		send_cmd(fill_cmd(16'h8000, 0));
		send_cmd(fill_cmd(16'h7FFF, 0));
		send_cmd(fill_cmd(16'h0000, 0));
		send_cmd(fill_cmd(16'hFFFF, 0));
		send_cmd(fill_cmd(16'h0100, 1));
		send_cmd(read_cmd()); // before reads: frame still open? no, closed; reads go out
		repeat (5) send_cmd(read_cmd());
		wait_idle();
	endtask

	task automatic test_zero_max();
		send_cmd(fill_cmd(16'h0000, 0));
		send_cmd(fill_cmd(16'h0000, 1));
		repeat (3) send_cmd(read_cmd());
		wait_idle();
	endtask

	task automatic test_register_extremes();
		logic [CfgIdxW-1:0] i;
		for (int k = 0; k < 8; k++) begin
			i = CfgIdxW'(k);
			write_reg(i, 16'hFFFF);
		end
		send_cmd(fill_cmd(16'h8000, 0));
		send_cmd(fill_cmd(16'h7FFF, 1));
		repeat (2) send_cmd(read_cmd());
		wait_idle();
		write_reg(REG_WEIGHT_NEAR, 16'h0000);
		write_reg(REG_WEIGHT_SECOND, 16'h0000);
		write_reg(REG_WEIGHT_THIRD, 16'h0000);
		write_reg(REG_WEIGHT_FAR, 16'h0000);
		write_reg(REG_MAG_GAIN, 16'h0000);
		send_cmd(fill_cmd(16'h1234, 1));
		send_cmd(read_cmd());
		wait_idle();
	endtask

	task automatic random_settings();
		write_reg(REG_WEIGHT_NEAR, 16'($urandom));
		write_reg(REG_WEIGHT_SECOND, 16'($urandom));
		write_reg(REG_WEIGHT_THIRD, 16'($urandom));
		write_reg(REG_WEIGHT_FAR, 16'($urandom));
		write_reg(REG_MAG_GAIN, 16'($urandom));
	endtask

	// frames of random content; some noise reads and overruns mixed in
	task automatic test_random_frames(int n_items);
		int sent;
		int npix;
		sent = 0;
		while (sent < n_items) begin
			npix = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			for (int p = 0; p < npix; p++) begin
				if ($urandom_range(19) == 0) begin
					send_cmd(read_cmd());
					sent++;
				end
				send_cmd(load_cmd(p == npix - 1));
				sent++;
			end
			for (int p = 0; p < npix + $urandom_range(0, 2); p++) begin
				if ($urandom_range(5) == 0 && p < npix) break;
				send_cmd(read_cmd());
				sent++;
			end
		end
	endtask

	initial begin
		weights[REG_WEIGHT_NEAR] = 16'd52429;
		weights[REG_WEIGHT_SECOND] = 16'd39322;
		weights[REG_WEIGHT_THIRD] = 16'd26214;
		weights[REG_WEIGHT_FAR] = 16'd13107;
		weights[REG_MAG_GAIN] = 16'd2570;
		pix_count = 0;
		frame_max = 0;
		frame_sum = 0;
		read_ptr = 0;
		frame_closed = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_read_before_frame();
		test_field_extremes();
		test_zero_max();
		test_register_extremes();

		random_settings();
		sender_idle_pct = 22;
		test_random_frames(270);
		wait_idle();
		write_reg(REG_WEIGHT_NEAR, 16'd52429);
		write_reg(REG_WEIGHT_SECOND, 16'd39322);
		write_reg(REG_WEIGHT_THIRD, 16'd26214);
		write_reg(REG_WEIGHT_FAR, 16'd13107);
		write_reg(REG_MAG_GAIN, 16'd2570);
		sender_idle_pct = 70;
		test_random_frames(270);
		wait_idle();
		random_settings();
		sender_idle_pct = 0;
		test_random_frames(270);

		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
